// ===== hw/rtl/hashed_key_value_table_defines.svh =====
// ----------------------------------------------------------------------------
// Hashed key/value table: assertion macros
// Concurrent assertion wrappers, which compile away when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef HASHED_KEY_VALUE_TABLE_DEFINES_SVH
`define HASHED_KEY_VALUE_TABLE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define HKVT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define HKVT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HKVT_ASSERT(lbl, clk, rst, prop, msg)
`define HKVT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== hw/rtl/hkvt_pkg.sv =====
// ----------------------------------------------------------------------------
// Hashed key/value table package
// Sizes, command and status codes, and the controller state type.
// ----------------------------------------------------------------------------
`default_nettype none

package hkvt_pkg;

   // Default sizes of the table.
   localparam int DEF_BUCKETS     = 128;
   localparam int DEF_ENTRIES     = 64;
   localparam int DEF_MAX_KEY_LEN = 49;

   // Starting value of the djb2 hash.
   localparam logic [31:0] HASH_SEED = 32'd5381;

   // Command codes; the unused code behaves as a read.
   localparam logic [1:0] CMD_SET  = 2'd0;
   localparam logic [1:0] CMD_GET  = 2'd1;
   localparam logic [1:0] CMD_INCR = 2'd2;

   // Status codes.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_KEY_LONG  = 2'd1;
   localparam logic [1:0] STATUS_POOL_FULL = 2'd2;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MOD,
      ST_HEAD,
      ST_LINK,
      ST_ENT,
      ST_CMP_RD,
      ST_CMP_CHK,
      ST_MISS,
      ST_FIN
   } state_type;

endpackage

`default_nettype wire

// ===== hw/rtl/hkvt_if.sv =====
// ----------------------------------------------------------------------------
// Hashed key/value table channels
// Request channel (one key byte per request) and response channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface hkvt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [7:0]  key_byte;
   logic        key_last;
   logic signed [31:0] new_value;

   modport source (output valid, cmd, key_byte, key_last, new_value, input ready);
   modport sink   (input valid, cmd, key_byte, key_last, new_value, output ready);
endinterface

interface hkvt_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic signed [31:0] count;
   logic [1:0]  status;

   modport source (output valid, found, count, status, input ready);
   modport sink   (input valid, found, count, status, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/hashed_key_value_table.sv =====
// ----------------------------------------------------------------------------
// Hashed key/value table
// String-keyed table with djb2 hashing and chained buckets held in RAM.
// ----------------------------------------------------------------------------
// Usage:
//  Each request on req_ch carries one key byte; key_last marks the final byte,
//  and the command and new_value of that request are then executed. A request
//  without key_last gives no response. The final request gives exactly one
//  response on rsp_ch: found, count and status.
//  Steps of a command: the modulo of the hash by the bucket count (four hash
//  bits a cycle), the bucket head read, then per chained entry visited its
//  length check and, per key byte compared, one RAM read and one compare;
//  then, after a hit, the output is loaded, or after a miss the entry is
//  inserted or the answer set, and then the output is loaded.
//  A key that is too long goes from its last byte straight to the output load.
//  After reset a clearing pass empties the bucket heads; no request is taken
//  during it.
//  The response is held in an output register until taken. Key bytes of the
//  next command are accepted while it waits; its final byte is accepted too,
//  and its response waits for the register to empty.
// ----------------------------------------------------------------------------
`default_nettype none

`include "hashed_key_value_table_defines.svh"

module hashed_key_value_table
   import hkvt_pkg::*;
#(
   parameter int BUCKETS     = DEF_BUCKETS,
   parameter int ENTRIES     = DEF_ENTRIES,
   parameter int MAX_KEY_LEN = DEF_MAX_KEY_LEN
) (
   input  wire        clock,
   input  wire        reset,
   hkvt_req_if.sink   req_ch,
   hkvt_rsp_if.source rsp_ch
);

   localparam int EW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int LW  = $clog2(ENTRIES + 1);
   localparam int KIW = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
   localparam int KLW = $clog2(MAX_KEY_LEN + 1);
   localparam int BW  = $clog2(BUCKETS);
   localparam int MW  = BW + 1;
   localparam int KB_DEPTH = 1 << KIW;
   localparam int EKB_DEPTH = ENTRIES * KB_DEPTH;

   // Memories.
   logic [7:0]      kb_mem   [KB_DEPTH];
   logic [7:0]      ekb_mem  [EKB_DEPTH];
   logic [LW-1:0]   bh_mem   [BUCKETS];
   logic [LW-1:0]   next_mem [ENTRIES];
   logic [31:0]     cnt_mem  [ENTRIES];
   logic [KLW-1:0]  klen_mem [ENTRIES];

   // Control and data registers.
   state_type       state_ff, state_in;
   logic [BW-1:0]   clr_ff, clr_in;
   logic [31:0]     hash_ff, hash_in;
   logic [KLW-1:0]  key_len_ff, key_len_in;
   logic            ovf_ff, ovf_in;
   logic [LW-1:0]   used_ff, used_in;
   logic [1:0]      cmd_ff, cmd_in;
   logic [31:0]     value_ff, value_in;
   logic [31:0]     div_ff, div_in;
   logic [BW-1:0]   rem_ff, rem_in;
   logic [4:0]      mod_cnt_ff, mod_cnt_in;
   logic [LW-1:0]   head_ff, head_in;
   logic [EW-1:0]   cur_ff, cur_in;
   logic [LW-1:0]   next_ff, next_in;
   logic [31:0]     ecnt_ff, ecnt_in;
   logic [KIW-1:0]  idx_ff, idx_in;
   logic            res_found_ff, res_found_in;
   logic [31:0]     res_count_ff, res_count_in;
   logic [1:0]      res_status_ff, res_status_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            rsp_found_ff, rsp_found_in;
   logic [31:0]     rsp_count_ff, rsp_count_in;
   logic [1:0]      rsp_status_ff, rsp_status_in;

   // Registered read data.
   logic [7:0]      kb_rd, ekb_rd;
   logic [LW-1:0]   bh_rd, next_rd;
   logic [31:0]     cnt_rd;
   logic [KLW-1:0]  klen_rd;

   // Memory access controls.
   logic            kb_we, ekb_we, bh_we, cnt_we, link_we;
   logic [BW-1:0]   bh_waddr;
   logic [LW-1:0]   bh_wdata;
   logic [EW-1:0]   ent_raddr, ent_waddr;
   logic [31:0]     cnt_wdata;

   logic            req_fire;
   logic [31:0]     hash_next;
   logic [MW-1:0]   rem_work;
   logic            key_room, pool_room, is_write;
   logic [LW-1:0]   follow;

   assign req_fire  = req_ch.valid && req_ch.ready;
   assign hash_next = (hash_ff << 5) + hash_ff + {24'd0, req_ch.key_byte};
   assign key_room  = key_len_ff < KLW'(MAX_KEY_LEN);
   assign pool_room = used_ff < LW'(ENTRIES);
   assign is_write  = (cmd_ff == CMD_SET) || (cmd_ff == CMD_INCR);

   // Four steps of shift, compare and subtract on the top hash bits.
   always_comb begin
      rem_work = {1'b0, rem_ff};
      for (int j = 0; j < 4; j++) begin
         rem_work = {rem_work[BW-1:0], div_ff[31 - j]};
         if (rem_work >= MW'(BUCKETS)) begin
            rem_work = rem_work - MW'(BUCKETS);
         end
      end
   end

   // Link to follow after a failed match.
   assign follow = (state_ff == ST_ENT) ? next_rd : next_ff;

   // Key buffer and staging slot of the entry key bytes.
   always_ff @(posedge clock) begin
      if (kb_we) begin
         kb_mem[key_len_ff[KIW-1:0]] <= req_ch.key_byte;
      end
      if (ekb_we) begin
         ekb_mem[{used_ff[EW-1:0], key_len_ff[KIW-1:0]}] <= req_ch.key_byte;
      end
      kb_rd  <= kb_mem[idx_ff];
      ekb_rd <= ekb_mem[{cur_ff, idx_ff}];
   end

   // Bucket heads.
   always_ff @(posedge clock) begin
      if (bh_we) begin
         bh_mem[bh_waddr] <= bh_wdata;
      end
      bh_rd <= bh_mem[rem_ff];
   end

   // Entry records.
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[ent_waddr] <= cnt_wdata;
      end
      if (link_we) begin
         next_mem[ent_waddr] <= head_ff;
         klen_mem[ent_waddr] <= key_len_ff;
      end
      cnt_rd  <= cnt_mem[ent_raddr];
      next_rd <= next_mem[ent_raddr];
      klen_rd <= klen_mem[ent_raddr];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         hash_ff      <= HASH_SEED;
         key_len_ff   <= '0;
         ovf_ff       <= 1'b0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         hash_ff      <= hash_in;
         key_len_ff   <= key_len_in;
         ovf_ff       <= ovf_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Data registers.
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      value_ff      <= value_in;
      div_ff        <= div_in;
      rem_ff        <= rem_in;
      mod_cnt_ff    <= mod_cnt_in;
      head_ff       <= head_in;
      cur_ff        <= cur_in;
      next_ff       <= next_in;
      ecnt_ff       <= ecnt_in;
      idx_ff        <= idx_in;
      res_found_ff  <= res_found_in;
      res_count_ff  <= res_count_in;
      res_status_ff <= res_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Next state and datapath control.
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      hash_in       = hash_ff;
      key_len_in    = key_len_ff;
      ovf_in        = ovf_ff;
      used_in       = used_ff;
      cmd_in        = cmd_ff;
      value_in      = value_ff;
      div_in        = div_ff;
      rem_in        = rem_ff;
      mod_cnt_in    = mod_cnt_ff;
      head_in       = head_ff;
      cur_in        = cur_ff;
      next_in       = next_ff;
      ecnt_in       = ecnt_ff;
      idx_in        = idx_ff;
      res_found_in  = res_found_ff;
      res_count_in  = res_count_ff;
      res_status_in = res_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      kb_we         = 1'b0;
      ekb_we        = 1'b0;
      bh_we         = 1'b0;
      bh_waddr      = clr_ff;
      bh_wdata      = '0;
      cnt_we        = 1'b0;
      link_we       = 1'b0;
      ent_waddr     = cur_ff;
      cnt_wdata     = value_ff;
      ent_raddr     = cur_ff;
      req_ch.ready  = 1'b0;

      unique case (state_ff)
         // Empty every bucket after reset.
         ST_CLEAR: begin
            bh_we  = 1'b1;
            clr_in = clr_ff + BW'(1);
            if (clr_ff == BW'(BUCKETS - 1)) begin
               state_in = ST_IDLE;
            end
         end

         // Take one key byte: fold it into the hash and buffer it.
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_fire) begin
               hash_in = hash_next;
               if (key_room) begin
                  kb_we      = 1'b1;
                  ekb_we     = pool_room;
                  key_len_in = key_len_ff + KLW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_ch.key_last) begin
                  cmd_in     = req_ch.cmd;
                  value_in   = req_ch.new_value;
                  hash_in    = HASH_SEED;
                  ovf_in     = 1'b0;
                  div_in     = hash_next;
                  rem_in     = '0;
                  mod_cnt_in = '0;
                  if (ovf_ff || !key_room) begin
                     res_found_in  = 1'b0;
                     res_count_in  = '0;
                     res_status_in = STATUS_KEY_LONG;
                     state_in      = ST_FIN;
                  end else begin
                     state_in = ST_MOD;
                  end
               end
            end
         end

         // Modulo of the hash by the bucket count, four bits a cycle.
         ST_MOD: begin
            div_in     = {div_ff[27:0], 4'd0};
            mod_cnt_in = mod_cnt_ff + 5'd1;
            rem_in     = rem_work[BW-1:0];
            if (mod_cnt_ff == 5'd7) begin
               state_in = ST_HEAD;
            end
         end

         // Bucket head read in flight.
         ST_HEAD: begin
            state_in = ST_LINK;
         end

         // Start the chain walk at the bucket head.
         ST_LINK: begin
            head_in = bh_rd;
            if (bh_rd == '0) begin
               state_in = ST_MISS;
            end else begin
               ent_raddr = EW'(bh_rd - LW'(1));
               cur_in    = ent_raddr;
               state_in  = ST_ENT;
            end
         end

         // Entry record available: check its key length.
         ST_ENT: begin
            if (klen_rd == key_len_ff) begin
               next_in  = next_rd;
               ecnt_in  = cnt_rd;
               idx_in   = '0;
               state_in = ST_CMP_RD;
            end else if (follow == '0) begin
               state_in = ST_MISS;
            end else begin
               ent_raddr = EW'(follow - LW'(1));
               cur_in    = ent_raddr;
            end
         end

         // Key byte reads in flight.
         ST_CMP_RD: begin
            state_in = ST_CMP_CHK;
         end

         // Compare one key byte; on a full match execute the command.
         ST_CMP_CHK: begin
            if (kb_rd != ekb_rd) begin
               if (follow == '0) begin
                  state_in = ST_MISS;
               end else begin
                  ent_raddr = EW'(follow - LW'(1));
                  cur_in    = ent_raddr;
                  state_in  = ST_ENT;
               end
            end else if ((KLW'(idx_ff) + KLW'(1)) == key_len_ff) begin
               res_found_in  = 1'b1;
               res_status_in = STATUS_OK;
               state_in      = ST_FIN;
               if (cmd_ff == CMD_SET) begin
                  cnt_we       = 1'b1;
                  cnt_wdata    = value_ff;
                  res_count_in = value_ff;
               end else if (cmd_ff == CMD_INCR) begin
                  cnt_we       = 1'b1;
                  cnt_wdata    = ecnt_ff + 32'd1;
                  res_count_in = ecnt_ff + 32'd1;
               end else begin
                  res_count_in = ecnt_ff;
               end
            end else begin
               idx_in   = idx_ff + KIW'(1);
               state_in = ST_CMP_RD;
            end
         end

         // Key not present: read miss, pool full, or insert at chain head.
         ST_MISS: begin
            res_found_in = 1'b0;
            state_in     = ST_FIN;
            if (!is_write) begin
               res_count_in  = 32'hFFFF_FFFF;
               res_status_in = STATUS_OK;
            end else if (!pool_room) begin
               res_count_in  = '0;
               res_status_in = STATUS_POOL_FULL;
            end else begin
               ent_waddr     = used_ff[EW-1:0];
               cnt_we        = 1'b1;
               link_we       = 1'b1;
               cnt_wdata     = (cmd_ff == CMD_SET) ? value_ff : 32'd1;
               bh_we         = 1'b1;
               bh_waddr      = rem_ff;
               bh_wdata      = used_ff + LW'(1);
               used_in       = used_ff + LW'(1);
               res_count_in  = cnt_wdata;
               res_status_in = STATUS_OK;
            end
         end

         // Load the response once the output register is free.
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = res_found_ff;
               rsp_count_in  = res_count_ff;
               rsp_status_in = res_status_ff;
               key_len_in    = '0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.found  = rsp_found_ff;
   assign rsp_ch.count  = rsp_count_ff;
   assign rsp_ch.status = rsp_status_ff;

   // Assertions.
   `HKVT_ASSERT(a_used_bound, clock, reset, (used_ff <= LW'(ENTRIES)), "entry pool overrun")
   `HKVT_ASSERT(a_used_step, clock, reset, (used_ff != $past(used_ff)) |-> (used_ff == $past(used_ff) + LW'(1)), "entry pool grew by more than one")
   `HKVT_ASSERT(a_no_req_clear, clock, reset, (state_ff == ST_CLEAR) |-> !req_ch.ready, "request taken during clearing pass")
   `HKVT_ASSERT(a_load_free, clock, reset, (state_ff == ST_FIN && rsp_valid_ff && !rsp_ch.ready) |=> (state_ff == ST_FIN), "response overwritten while pending")

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Hashed key/value table testbench
// Sends keys byte by byte with set, get and increment commands, predicts each
// response from its own copy of the table contents, and checks every response
// field against that prediction under random idling on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   import hkvt_pkg::*;

   localparam int MAX_KEY       = DEF_MAX_KEY_LEN;
   localparam int POOL_SIZE     = DEF_ENTRIES;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int DRAIN_CYCLES  = 7000;
   localparam int RANDOM_ITEMS  = 1500;
   localparam int KEY_SET_SIZE  = 100;

   typedef logic [7:0] key_bytes_type[$];

   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  key_byte;
      logic        key_last;
      logic [31:0] new_value;
   } request_type;

   typedef struct packed {
      logic        found;
      logic [31:0] count;
      logic [1:0]  status;
   } response_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hkvt_req_if req_ch ();
   hkvt_rsp_if rsp_ch ();

   hashed_key_value_table dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   always #6 clock = ~clock;

   request_type   pending_requests[$];
   response_type  expected_responses[$];
   key_bytes_type key_set[KEY_SET_SIZE];

   // Shadow of the table contents, indexed by the key written as hex text.
   logic [31:0] table_values[string];
   int          table_used = 0;
   string       rx_key = "";
   int          rx_length = 0;

   bit failed = 1'b0;
   bit req_taken = 1'b0;
   int requests_taken = 0;
   int send_gap = 0;

   // Queue one command: the key bytes, with the command on the final one.
   task automatic queue_command(input logic [1:0] cmd, input key_bytes_type key,
                                input logic [31:0] value);
      request_type r;
      foreach (key[i]) begin
         r.cmd       = (i == key.size() - 1) ? cmd : 2'($urandom_range(0, 3));
         r.key_byte  = key[i];
         r.key_last  = (i == key.size() - 1);
         r.new_value = (i == key.size() - 1) ? value : $urandom;
         pending_requests.push_back(r);
      end
   endtask

   function automatic key_bytes_type random_key(input int len);
      key_bytes_type k;
      for (int i = 0; i < len; i++)
         k.push_back(8'($urandom_range(1, 255)));
      return k;
   endfunction

   // Work out the response of a command from the shadow table.
   function automatic response_type predict_response(input logic [1:0] cmd,
                                                     input logic [31:0] value);
      response_type p;
      p = '{found: 1'b0, count: 32'd0, status: STATUS_OK};
      if (rx_length > MAX_KEY) begin
         p.status = STATUS_KEY_LONG;
      end else if (cmd == CMD_SET || cmd == CMD_INCR) begin
         if (table_values.exists(rx_key)) begin
            table_values[rx_key] = (cmd == CMD_SET) ? value : table_values[rx_key] + 32'd1;
            p.found = 1'b1;
            p.count = table_values[rx_key];
         end else if (table_used >= POOL_SIZE) begin
            p.status = STATUS_POOL_FULL;
         end else begin
            table_values[rx_key] = (cmd == CMD_SET) ? value : 32'd1;
            table_used++;
            p.count = table_values[rx_key];
         end
      end else if (table_values.exists(rx_key)) begin
         p.found = 1'b1;
         p.count = table_values[rx_key];
      end else begin
         p.count = 32'hFFFF_FFFF;
      end
      return p;
   endfunction

   // Request side: note each accepted request and predict on its final byte.
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         req_taken <= 1'b1;
         requests_taken <= requests_taken + 1;
         if (rx_length < MAX_KEY)
            rx_key = $sformatf("%s%02x", rx_key, req_ch.key_byte);
         rx_length++;
         if (req_ch.key_last) begin
            expected_responses.push_back(predict_response(req_ch.cmd, req_ch.new_value));
            rx_key = "";
            rx_length = 0;
         end
      end else begin
         req_taken <= 1'b0;
      end
   end

   // Response side: compare each accepted response with the oldest prediction.
   always @(posedge clock) begin
      response_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_responses.size() == 0) begin
            $display("%0t: unexpected response found=%0b count=%0d status=%0d",
                     $time, rsp_ch.found, rsp_ch.count, rsp_ch.status);
            failed = 1'b1;
         end else begin
            want = expected_responses.pop_front();
            if (rsp_ch.found !== want.found) begin
               $display("%0t: found expected %0b actual %0b", $time, want.found, rsp_ch.found);
               failed = 1'b1;
            end
            if (rsp_ch.count !== want.count) begin
               $display("%0t: count expected %0d actual %0d",
                        $time, $signed(want.count), rsp_ch.count);
               failed = 1'b1;
            end
            if (rsp_ch.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_ch.status);
               failed = 1'b1;
            end
         end
      end
   end

   // Driver: present the next request after a random gap, mostly short.
   always @(negedge clock) begin
      request_type r;
      int pick;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         if (req_taken) begin
            pick = $urandom_range(0, 99);
            send_gap = (pick < 65) ? 0 : (pick < 95) ? $urandom_range(1, 3)
                                                     : $urandom_range(10, 40);
         end
         if (send_gap == 0 && pending_requests.size() > 0) begin
            r = pending_requests.pop_front();
            req_ch.valid     <= 1'b1;
            req_ch.cmd       <= r.cmd;
            req_ch.key_byte  <= r.key_byte;
            req_ch.key_last  <= r.key_last;
            req_ch.new_value <= r.new_value;
         end else begin
            req_ch.valid <= 1'b0;
            if (send_gap > 0)
               send_gap--;
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off while requests keep coming.
   int  stall_left = 0;
   bit  long_hold_done = 1'b0;
   always @(negedge clock) begin
      int pick;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (!long_hold_done && requests_taken > 400) begin
         long_hold_done = 1'b1;
         stall_left = 600;
         rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         pick = $urandom_range(0, 99);
         if (requests_taken > 1200 && requests_taken < 1500)
            rsp_ch.ready <= 1'b1;
         else if (pick < 70)
            rsp_ch.ready <= 1'b1;
         else begin
            stall_left = (pick < 96) ? $urandom_range(0, 3) : $urandom_range(10, 60);
            rsp_ch.ready <= 1'b0;
         end
      end
   end

   // Run limit.
   int cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      key_bytes_type k;
      int total;
      req_ch.valid     = 1'b0;
      req_ch.cmd       = CMD_GET;
      req_ch.key_byte  = 8'd1;
      req_ch.key_last  = 1'b0;
      req_ch.new_value = 32'd0;
      rsp_ch.ready     = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed commands: misses, extreme values, wrap, unused code, key lengths.
      k = '{8'h01};
      queue_command(CMD_GET, k, 32'd0);
      queue_command(CMD_SET, k, 32'h7FFF_FFFF);
      queue_command(CMD_GET, k, 32'd0);
      queue_command(CMD_INCR, k, 32'd0);
      queue_command(CMD_SET, k, 32'hFFFF_FFFF);
      queue_command(CMD_INCR, k, 32'd0);
      k = '{8'hFF, 8'h80};
      queue_command(CMD_SET, k, 32'h8000_0000);
      queue_command(2'd3, k, 32'd0);
      k = '{8'h55, 8'hAA, 8'h7F};
      queue_command(CMD_INCR, k, 32'd0);
      queue_command(2'd3, k, 32'd0);
      k = random_key(MAX_KEY);
      queue_command(CMD_SET, k, 32'd12345);
      queue_command(CMD_GET, k, 32'd0);
      k.push_back(8'h42);
      queue_command(CMD_INCR, k, 32'd0);
      queue_command(CMD_SET, k, 32'd7);

      // Key set for the random part: mostly short keys, a few longer up to full length or too long.
      for (int i = 0; i < KEY_SET_SIZE; i++) begin
         total = $urandom_range(0, 99);
         key_set[i] = random_key(total < 80 ? $urandom_range(1, 6)
                               : total < 94 ? $urandom_range(7, MAX_KEY)
                                            : $urandom_range(MAX_KEY + 1, MAX_KEY + 6));
      end
      total = 0;
      while (total < RANDOM_ITEMS) begin
         k = key_set[$urandom_range(0, KEY_SET_SIZE - 1)];
         total += k.size();
         queue_command(2'($urandom_range(0, 3)), k, $urandom);
      end

      wait (pending_requests.size() == 0);
      @(posedge clock);
      wait (!req_ch.valid && expected_responses.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (!failed && expected_responses.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

`default_nettype wire
